@@ sv/gfd_pkg.sv @@
// ----------------------------------------------------------------------------
// gfd_pkg
// Shared types and constants for the gyro frame deframer.
// ----------------------------------------------------------------------------
package gfd_pkg;

   // byte position within a frame
   localparam logic [3:0] POS_IDLE  = 4'd0;
   localparam logic [3:0] POS_FIRST = 4'd1;
   localparam logic [3:0] POS_LAST  = 4'd8;
   localparam logic [3:0] POS_LIMIT = 4'd9;

   // frame start marker in a received byte
   localparam int unsigned SYNC_BIT = 7;
   // temperature byte flag: set means low bits only
   localparam int unsigned TEMP_LOW_FLAG = 7;

   // decoded result of one frame
   typedef struct packed {
      logic signed [15:0] rate_raw;
      logic        [7:0]  status_byte;
      logic        [15:0] word_b;
      logic        [13:0] temperature_raw;
      logic               temperature_ready;
      logic               checksum_ok;
   } result_type;

   // check and temperature outcome from the check stage
   typedef struct packed {
      logic        checksum_ok;
      logic        temperature_ready;
      logic [13:0] temperature_raw;
      logic        low_bits_load;
      logic [6:0]  low_bits;
   } check_type;

endpackage

@@ sv/gfd_check.sv @@
// ----------------------------------------------------------------------------
// gfd_check
// Frame check byte comparison and temperature assembly for a complete frame.
// ----------------------------------------------------------------------------
module gfd_check (
   input  logic [7:0]          check_value,
   input  logic [15:0]         b_value,
   input  logic [7:0]          c_value,
   input  logic [7:0]          t_value,
   input  logic [15:0]         r_value,
   input  logic [6:0]          temp_low_bits,
   output gfd_pkg::check_type  check
);

   logic [7:0] sum;
   logic [7:0] expected;

   // byte sum of R, T, C and B, wrapping at 8 bits
   assign sum = r_value[7:0] + r_value[15:8] + t_value + c_value
              + b_value[7:0] + b_value[15:8];
   assign expected = ~(sum - 8'd1);

   // pick the temperature form when the check passes
   always_comb begin
      check.checksum_ok       = (expected == check_value);
      check.temperature_ready = 1'b0;
      check.temperature_raw   = '0;
      check.low_bits_load     = 1'b0;
      check.low_bits          = t_value[6:0];
      if (check.checksum_ok) begin
         if (t_value[gfd_pkg::TEMP_LOW_FLAG]) begin
            check.low_bits_load   = 1'b1;
            check.temperature_raw = {7'd0, t_value[6:0]};
         end else begin
            check.temperature_ready = 1'b1;
            check.temperature_raw   = {t_value[6:0], temp_low_bits};
         end
      end
   end

endmodule

@@ sv/gyro_frame_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// gyro_frame_deframer_unit
// Unpacks serial gyro frames, one byte per transaction, and emits one decoded
// result on the eighth byte of each frame.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req     | in        | rx_byte (8)
//  rsp     | out       | rate_raw, status_byte, word_b, temperature_raw,
//          |           | temperature_ready, checksum_ok
//
//  One byte per cycle while req_ready is high; the unpack and frame check sit
//  between the frame state registers and the result register, so a result
//  appears in the cycle after its eighth byte is taken. Synchronous reset clears
//  the byte position and all frame state. A stalled result holds its register;
//  req_ready stays high while that register is empty or being drained.
// ----------------------------------------------------------------------------
module gyro_frame_deframer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_rate_raw,
   output logic [7:0]         rsp_status_byte,
   output logic [15:0]        rsp_word_b,
   output logic [13:0]        rsp_temperature_raw,
   output logic               rsp_temperature_ready,
   output logic               rsp_checksum_ok
);

   logic [3:0]  pos_ff,   pos_in;
   logic [7:0]  check_ff, check_in;
   logic [15:0] b_ff,     b_in;
   logic [7:0]  c_ff,     c_in;
   logic [7:0]  t_ff,     t_in;
   logic [15:0] r_ff,     r_in;
   logic [6:0]  low_ff;
   logic        rsp_valid_ff;
   gfd_pkg::result_type result_ff, result_in;
   gfd_pkg::check_type  check;
   logic        accept;
   logic        frame_done;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign frame_done = accept && (pos_in == gfd_pkg::POS_LAST);

   // advance the byte position, restart on sync, saturate past the frame
   always_comb begin
      if (req_rx_byte[gfd_pkg::SYNC_BIT]) begin
         pos_in = gfd_pkg::POS_FIRST;
      end else if (pos_ff < gfd_pkg::POS_LIMIT) begin
         pos_in = pos_ff + 4'd1;
      end else begin
         pos_in = pos_ff;
      end
   end

   // unpack the 7-bit payload of the current byte into the frame fields
   always_comb begin
      check_in = check_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      t_in     = t_ff;
      r_in     = r_ff;
      case (pos_in)
         4'd1: begin
            check_in = {req_rx_byte[6:0], 1'b0};
         end
         4'd2: begin
            check_in = check_ff + {7'd0, req_rx_byte[6]};
            b_in     = {req_rx_byte[5:0], 10'd0};
         end
         4'd3: begin
            b_in = b_ff + {6'd0, req_rx_byte[6:0], 3'd0};
         end
         4'd4: begin
            b_in = b_ff + {13'd0, req_rx_byte[6:4]};
            c_in = {req_rx_byte[3:0], 4'd0};
         end
         4'd5: begin
            c_in = c_ff + {4'd0, req_rx_byte[6:3]};
            t_in = {req_rx_byte[2:0], 5'd0};
         end
         4'd6: begin
            t_in = t_ff + {3'd0, req_rx_byte[6:2]};
            r_in = {req_rx_byte[1:0], 14'd0};
         end
         4'd7: begin
            r_in = r_ff + {2'd0, req_rx_byte[6:0], 7'd0};
         end
         4'd8: begin
            r_in = r_ff + {9'd0, req_rx_byte[6:0]};
         end
         default: begin
         end
      endcase
   end

   // check the completed frame
   gfd_check u_check (
      .check_value   (check_in),
      .b_value       (b_in),
      .c_value       (c_in),
      .t_value       (t_in),
      .r_value       (r_in),
      .temp_low_bits (low_ff),
      .check         (check)
   );

   // assemble the result transaction
   always_comb begin
      result_in.rate_raw          = r_in;
      result_in.status_byte       = c_in;
      result_in.word_b            = b_in;
      result_in.temperature_raw   = check.temperature_raw;
      result_in.temperature_ready = check.temperature_ready;
      result_in.checksum_ok       = check.checksum_ok;
   end

   // hold frame state, update on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= gfd_pkg::POS_IDLE;
         check_ff <= '0;
         b_ff     <= '0;
         c_ff     <= '0;
         t_ff     <= '0;
         r_ff     <= '0;
         low_ff   <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         check_ff <= check_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
         t_ff     <= t_in;
         r_ff     <= r_in;
         if (frame_done && check.low_bits_load) begin
            low_ff <= check.low_bits;
         end
      end
   end

   // result register: load on frame end, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (frame_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_rate_raw          = result_ff.rate_raw;
   assign rsp_status_byte       = result_ff.status_byte;
   assign rsp_word_b            = result_ff.word_b;
   assign rsp_temperature_raw   = result_ff.temperature_raw;
   assign rsp_temperature_ready = result_ff.temperature_ready;
   assign rsp_checksum_ok       = result_ff.checksum_ok;

endmodule

@@ sv/gfd_checker.sv @@
// ----------------------------------------------------------------------------
// gfd_checker
// Port-level checks for the gyro frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module gfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_rate_raw,
   input logic [13:0]        rsp_temperature_raw,
   input logic               rsp_temperature_ready,
   input logic               rsp_checksum_ok
);

   // a result only follows an accepted byte
   a_rsp_after_req : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid && !rsp_ready)) |-> $past(req_valid && req_ready))
      else $error("result transaction without an accepted byte");

   // a pending result holds until taken
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_rate_raw)))
      else $error("pending result changed before it was taken");

   // a failed check carries no temperature
   a_fail_no_temp : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_checksum_ok) |->
         (!rsp_temperature_ready && rsp_temperature_raw == 14'd0))
      else $error("temperature reported on a failed check");

   // never refuse a byte while the result register is empty
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("byte refused with an empty result register");

endmodule

bind gyro_frame_deframer_unit gfd_checker u_gfd_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_rate_raw          (rsp_rate_raw),
   .rsp_temperature_raw   (rsp_temperature_raw),
   .rsp_temperature_ready (rsp_temperature_ready),
   .rsp_checksum_ok       (rsp_checksum_ok)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gyro_frame_deframer_unit. Serial bytes go in as
// whole frames with good or corrupted checks, cut-short frames, over-long
// frames and line noise. A bit-level frame decoder predicts every decoded
// result, and the results are compared field by field as they drain. Sender
// gaps and receiver stalls vary by phase, and one long receiver hold-off
// backs the block up.
// ----------------------------------------------------------------------------
module tb;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 12;
   localparam int PHASE_BYTES    = 310;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 20;
   localparam int STALL_LIMIT    = 2000;
   localparam int MAX_REPORTED   = 10;

   // Decode frames byte by byte and hold the results still owed by the block
   class frame_scoreboard;
      logic [3:0]  position;
      logic [7:0]  check_x;
      logic [15:0] word_b_acc;
      logic [7:0]  status_acc;
      logic [7:0]  temp_byte;
      logic [15:0] rate_acc;
      logic [6:0]  temp_low;
      gfd_pkg::result_type frames_owed[$];
      int          error_count;

      function new();
         position    = gfd_pkg::POS_IDLE;
         check_x     = '0;
         word_b_acc  = '0;
         status_acc  = '0;
         temp_byte   = '0;
         rate_acc    = '0;
         temp_low    = '0;
         error_count = 0;
      endfunction

      // Unpack one accepted byte; queue a result on the last byte of a frame
      function void note_byte(logic [7:0] rx);
         gfd_pkg::result_type frame;
         logic [7:0] byte_sum;
         logic [7:0] check_target;
         if (rx[gfd_pkg::SYNC_BIT])
            position = gfd_pkg::POS_FIRST;
         else if (position < gfd_pkg::POS_LIMIT)
            position = position + 4'd1;

         // each position spreads its payload bits over the frame fields
         case (position)
            gfd_pkg::POS_FIRST: check_x = {rx[6:0], 1'b0};
            4'd2: begin
               check_x    = check_x + {7'd0, rx[6]};
               word_b_acc = {rx[5:0], 10'd0};
            end
            4'd3: word_b_acc = word_b_acc + {6'd0, rx[6:0], 3'd0};
            4'd4: begin
               word_b_acc = word_b_acc + {13'd0, rx[6:4]};
               status_acc = {rx[3:0], 4'd0};
            end
            4'd5: begin
               status_acc = status_acc + {4'd0, rx[6:3]};
               temp_byte  = {rx[2:0], 5'd0};
            end
            4'd6: begin
               temp_byte = temp_byte + {3'd0, rx[6:2]};
               rate_acc  = {rx[1:0], 14'd0};
            end
            4'd7: rate_acc = rate_acc + {2'd0, rx[6:0], 7'd0};
            gfd_pkg::POS_LAST: rate_acc = rate_acc + {9'd0, rx[6:0]};
            default: ;
         endcase

         if (position == gfd_pkg::POS_LAST) begin
            byte_sum = rate_acc[7:0] + rate_acc[15:8] + temp_byte + status_acc
                     + word_b_acc[7:0] + word_b_acc[15:8];
            check_target = ~(byte_sum - 8'd1);
            frame.rate_raw          = rate_acc;
            frame.status_byte       = status_acc;
            frame.word_b            = word_b_acc;
            frame.temperature_raw   = '0;
            frame.temperature_ready = 1'b0;
            frame.checksum_ok       = (check_target == check_x);
            // only a good frame touches the temperature
            if (frame.checksum_ok) begin
               if (temp_byte[gfd_pkg::TEMP_LOW_FLAG]) begin
                  temp_low              = temp_byte[6:0];
                  frame.temperature_raw = {7'd0, temp_low};
               end else begin
                  frame.temperature_raw   = {temp_byte[6:0], temp_low};
                  frame.temperature_ready = 1'b1;
               end
            end
            frames_owed.push_back(frame);
         end
      endfunction

      function void compare_field(string field, logic signed [31:0] want,
                                  logic signed [31:0] seen);
         if (want !== seen) begin
            error_count++;
            if (error_count <= MAX_REPORTED)
               $display("%0t: %s mismatch, expected %0d, got %0d",
                        $realtime, field, want, seen);
         end
      endfunction

      // Compare a drained result against the oldest owed frame
      function void check_frame(gfd_pkg::result_type seen);
         gfd_pkg::result_type want;
         if (frames_owed.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTED)
               $display("%0t: result with no frame outstanding", $realtime);
         end else begin
            want = frames_owed.pop_front();
            compare_field("rate_raw", 32'(want.rate_raw), 32'(seen.rate_raw));
            compare_field("status_byte", 32'(want.status_byte),
                          32'(seen.status_byte));
            compare_field("word_b", 32'(want.word_b), 32'(seen.word_b));
            compare_field("temperature_raw", 32'(want.temperature_raw),
                          32'(seen.temperature_raw));
            compare_field("temperature_ready", 32'(want.temperature_ready),
                          32'(seen.temperature_ready));
            compare_field("checksum_ok", 32'(want.checksum_ok),
                          32'(seen.checksum_ok));
         end
      endfunction

      function int pending();
         return frames_owed.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_rate_raw;
   logic [7:0]         rsp_status_byte;
   logic [15:0]        rsp_word_b;
   logic [13:0]        rsp_temperature_raw;
   logic               rsp_temperature_ready;
   logic               rsp_checksum_ok;

   frame_scoreboard     scoreboard = new();
   gfd_pkg::result_type drained_frame;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   int                  hold_asked = 0;
   int                  bytes_sent = 0;

   gyro_frame_deframer_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_rate_raw          (rsp_rate_raw),
      .rsp_status_byte       (rsp_status_byte),
      .rsp_word_b            (rsp_word_b),
      .rsp_temperature_raw   (rsp_temperature_raw),
      .rsp_temperature_ready (rsp_temperature_ready),
      .rsp_checksum_ok       (rsp_checksum_ok)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Observe both channels; note the byte before checking any result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            scoreboard.note_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            drained_frame.rate_raw          = rsp_rate_raw;
            drained_frame.status_byte       = rsp_status_byte;
            drained_frame.word_b            = rsp_word_b;
            drained_frame.temperature_raw   = rsp_temperature_raw;
            drained_frame.temperature_ready = rsp_temperature_ready;
            drained_frame.checksum_ok       = rsp_checksum_ok;
            scoreboard.check_frame(drained_frame);
         end
      end
   end

   // Drive the receiver: random stalls, or a long hold-off when asked
   initial begin
      int hold_left;
      int hold_taken;
      hold_left  = 0;
      hold_taken = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // End the run when no transaction moves for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Offer one byte after a random gap and hold it until it is taken
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      bytes_sent++;
   endtask

   // Pack B, C, T and R into a frame and send its first len bytes
   task automatic send_frame(input logic [15:0] b, input logic [7:0] c,
                             input logic [7:0] t, input logic [15:0] r,
                             input bit good, input int len, input bit with_sync);
      logic [7:0] frame_bytes[8];
      logic [7:0] byte_sum;
      logic [7:0] x;
      byte_sum = b[15:8] + b[7:0] + c + t + r[15:8] + r[7:0];
      x = ~(byte_sum - 8'd1);
      if (!good)
         x = x ^ (8'd1 << $urandom_range(7));
      frame_bytes[0] = {1'b1, x[7:1]};
      frame_bytes[1] = {1'b0, x[0], b[15:10]};
      frame_bytes[2] = {1'b0, b[9:3]};
      frame_bytes[3] = {1'b0, b[2:0], c[7:4]};
      frame_bytes[4] = {1'b0, c[3:0], t[7:5]};
      frame_bytes[5] = {1'b0, t[4:0], r[15:14]};
      frame_bytes[6] = {1'b0, r[13:7]};
      frame_bytes[7] = {1'b0, r[6:0]};
      if (!with_sync)
         frame_bytes[0][gfd_pkg::SYNC_BIT] = 1'b0;
      for (int i = 0; i < len; i++)
         send_byte(frame_bytes[i]);
   endtask

   // Send one burst: mostly whole frames, some cut short, overlong or noise
   task automatic random_traffic();
      int pick;
      int extra;
      pick = $urandom_range(99);
      if (pick < 94) begin
         send_frame(16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                    $urandom_range(99) < 80,
                    (pick < 80 || pick >= 88) ? 8 : $urandom_range(7, 1), 1'b1);
         // overlong frame: trailing bytes without sync are ignored
         if (pick >= 88) begin
            extra = $urandom_range(3, 1);
            repeat (extra) send_byte({1'b0, 7'($urandom)});
         end
      end else begin
         extra = $urandom_range(4, 1);
         repeat (extra) send_byte(8'($urandom_range(255)));
      end
   endtask

   // Hold the sender off until every owed result has drained
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (scoreboard.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      int send_idle_by_phase[4];
      int stall_by_phase[4];
      int phase_end;
      send_idle_by_phase = '{0, 76, 0, 16};
      stall_by_phase     = '{0, 0, 76, 16};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // first frame has no sync byte and uses full temperature before low bits
      send_frame(16'hFFFF, 8'h00, 8'h55, 16'h8000, 1'b1, 8, 1'b0);
      // overlong frame tail
      send_byte(8'h00);
      send_byte(8'h7F);
      // failed check with the low-bits flag set must not store them
      send_frame(16'h0000, 8'hFF, 8'hFF, 16'h7FFF, 1'b0, 8, 1'b1);
      // good frame storing low temperature bits
      send_frame(16'h5A5A, 8'h80, 8'h81, 16'h0000, 1'b1, 8, 1'b1);
      pause_until_drained();

      // random traffic under each mix of sender gaps and receiver stalls
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_idle_by_phase[phase];
         stall_pct     = stall_by_phase[phase];
         if (phase == 0)
            hold_asked++;
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end)
            random_traffic();
         pause_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.error_count == 0 && scoreboard.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
